>>> rtl/ledbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ledbs_pkg
// Shared types and constants for the LED blink and shift-out controller.
// ----------------------------------------------------------------------------
package ledbs_pkg;

  // request kinds, carried on s_axis_tuser
  typedef enum logic [1:0] {
    REQ_BLINK_TICK = 2'd0,
    REQ_SHIFT_TICK = 2'd1,
    REQ_SET_LEDS   = 2'd2,
    REQ_BLINK_LEDS = 2'd3
  } req_type_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_BLINK_PRESCALE   = 2'd0,
    CFG_SHIFT_BITS       = 2'd1,
    CFG_SHIFT_PERIOD     = 2'd2,
    CFG_CLOCK_HIGH_AFTER = 2'd3
  } cfg_index_t;

  localparam int MASK_W      = 16;
  localparam int TIMER_W     = 8;
  localparam int PRESCALE_W  = 16;
  localparam int SPHASE_W    = 16;
  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = 40;
  localparam int CFG_DATA_W  = 16;

  localparam logic [TIMER_W-1:0]  COUNT_FOREVER      = 8'd255;
  localparam logic [SPHASE_W-1:0] SHIFT_PERIOD_RESET = 16'd2;

endpackage

>>> rtl/led_blink_and_shift_out_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_blink_and_shift_out_controller_top
// LED pattern with per-LED blink timers, driven out serially to an external
// shift register (clock, data, strobe).
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          tuser: req_type; tdata: masks, timing
// m_axis    out  tvalid/tready          tdata: pattern, blink mask, pins, busy
// cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One word per cycle while skid stage is empty; result registered to m_axis.
// All per-LED timers update in parallel in a single registered pass.
// Output side is a register plus a skid stage, so s_axis_tready drops only
// when both hold a word (the cycle after a word is accepted while m_axis stalls).
// Sync active-high reset clears all but out/skid data; shift_period resets to 2.
// cfg is always ready.
// ----------------------------------------------------------------------------
module led_blink_and_shift_out_controller_top
  import ledbs_pkg::*;
#(
  parameter int NUM_LEDS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [15:0] on_mask, [31:16] off_mask, [39:32] period, [47:40] on_time,
  // [55:48] repeat_count
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [15:0] led_pattern, [31:16] blinking, [32] ser_clock, [33] ser_data,
  // [34] ser_strobe, [35] ser_busy, [39:36] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [PRESCALE_W-1:0] blink_prescale;
  logic [7:0]            shift_bits;
  logic [SPHASE_W-1:0]   shift_period;
  logic [SPHASE_W-1:0]   clock_high_after;

  // state
  logic [PRESCALE_W-1:0] prescale_count, prescale_count_next;
  logic [NUM_LEDS-1:0]   blink_active, blink_active_next;
  logic [TIMER_W-1:0]    phase [NUM_LEDS];
  logic [TIMER_W-1:0]    phase_next [NUM_LEDS];
  logic [TIMER_W-1:0]    cycle_len [NUM_LEDS];
  logic [TIMER_W-1:0]    cycle_len_next [NUM_LEDS];
  logic [TIMER_W-1:0]    off_phase [NUM_LEDS];
  logic [TIMER_W-1:0]    off_phase_next [NUM_LEDS];
  logic [TIMER_W-1:0]    cycles_left [NUM_LEDS];
  logic [TIMER_W-1:0]    cycles_left_next [NUM_LEDS];
  logic [NUM_LEDS-1:0]   pattern, pattern_next;
  logic                  pattern_changed, pattern_changed_next;
  logic [NUM_LEDS-1:0]   shift_word, shift_word_next;
  logic                  shifting, shifting_next;
  logic [SPHASE_W-1:0]   shift_phase, shift_phase_next;
  logic [7:0]            bits_left, bits_left_next;
  logic                  pin_clk, pin_clk_next;
  logic                  pin_dat, pin_dat_next;
  logic                  pin_str, pin_str_next;

  // output register and skid stage
  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;
  logic                  skid_valid;
  logic [OUT_DATA_W-1:0] skid_data;
  logic [OUT_DATA_W-1:0] result;

  // input fields
  req_type_t           req;
  logic [MASK_W-1:0]   on_mask, off_mask;
  logic [TIMER_W-1:0]  period, on_time, repeat_count;
  logic [31:0]         on32, off32, pat32, act32;
  logic [NUM_LEDS-1:0] on_v, off_v;
  logic                in_fire, out_fire;

  assign req          = req_type_t'(s_axis_tuser);
  assign on_mask      = s_axis_tdata[15:0];
  assign off_mask     = s_axis_tdata[31:16];
  assign period       = s_axis_tdata[39:32];
  assign on_time      = s_axis_tdata[47:40];
  assign repeat_count = s_axis_tdata[55:48];

  // mask bits at or above NUM_LEDS are dropped
  assign on32  = {16'd0, on_mask};
  assign off32 = {16'd0, off_mask};
  assign on_v  = on32[NUM_LEDS-1:0];
  assign off_v = off32[NUM_LEDS-1:0];

  assign s_axis_tready = !skid_valid;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = out_valid && m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_prescale   <= '0;
      shift_bits       <= '0;
      shift_period     <= SHIFT_PERIOD_RESET;
      clock_high_after <= '0;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_BLINK_PRESCALE:   blink_prescale   <= cfg_data;
        CFG_SHIFT_BITS:       shift_bits       <= cfg_data[7:0];
        CFG_SHIFT_PERIOD:     shift_period     <= cfg_data;
        CFG_CLOCK_HIGH_AFTER: clock_high_after <= cfg_data;
        default: ;
      endcase
    end
  end

  // next-state logic: one pass over all LEDs
  always_comb begin
    prescale_count_next  = prescale_count;
    blink_active_next    = blink_active;
    phase_next           = phase;
    cycle_len_next       = cycle_len;
    off_phase_next       = off_phase;
    cycles_left_next     = cycles_left;
    pattern_next         = pattern;
    pattern_changed_next = pattern_changed;
    shift_word_next      = shift_word;
    shifting_next        = shifting;
    shift_phase_next     = shift_phase;
    bits_left_next       = bits_left;
    pin_clk_next         = pin_clk;
    pin_dat_next         = pin_dat;
    pin_str_next         = pin_str;

    case (req)
      REQ_BLINK_TICK: begin
        if (prescale_count != blink_prescale) begin
          prescale_count_next = prescale_count + 1'b1;
        end else begin
          prescale_count_next = '0;
          for (int i = 0; i < NUM_LEDS; i++) begin
            if (blink_active[i]) begin
              if (phase[i] == '0) begin
                pattern_next[i]      = 1'b1;
                pattern_changed_next = 1'b1;
              end else if (phase[i] == off_phase[i]) begin
                pattern_next[i]      = 1'b0;
                pattern_changed_next = 1'b1;
              end
              if (phase[i] >= cycle_len[i]) begin
                phase_next[i] = '0;
                if (cycles_left[i] != COUNT_FOREVER) begin
                  if (cycles_left[i] == '0) begin
                    pattern_next[i]      = 1'b0;
                    pattern_changed_next = 1'b1;
                    blink_active_next[i] = 1'b0;
                  end else begin
                    cycles_left_next[i] = cycles_left[i] - 1'b1;
                  end
                end
              end else begin
                phase_next[i] = phase[i] + 1'b1;
              end
            end
          end
        end
      end
      REQ_SHIFT_TICK: begin
        if (shifting) begin
          if (shift_phase >= shift_period) begin
            shift_phase_next = '0;
          end else begin
            shift_phase_next = shift_phase + 1'b1;
          end
          pin_clk_next = (shift_phase_next > clock_high_after);
          if (shift_phase_next == '0) begin
            pin_dat_next    = shift_word[0];
            shift_word_next = shift_word >> 1;
            if (bits_left == '0) begin
              shifting_next = 1'b0;
              pin_str_next  = 1'b1;
            end
            bits_left_next = bits_left - 1'b1;
          end
        end else if (pattern_changed) begin
          shift_word_next      = pattern;
          pattern_changed_next = 1'b0;
          shift_phase_next     = '0;
          bits_left_next       = shift_bits;
          pin_str_next         = 1'b0;
          shifting_next        = 1'b1;
        end
      end
      REQ_SET_LEDS: begin
        blink_active_next    = blink_active & ~(on_v | off_v);
        pattern_next         = (pattern & ~off_v) | on_v;
        pattern_changed_next = 1'b1;
      end
      REQ_BLINK_LEDS: begin
        for (int i = 0; i < NUM_LEDS; i++) begin
          if (on_v[i]) begin
            if (!blink_active[i]) begin
              phase_next[i] = '0;
            end
            cycle_len_next[i]   = period;
            off_phase_next[i]   = on_time;
            cycles_left_next[i] = repeat_count;
          end
        end
        blink_active_next = blink_active | on_v;
      end
      default: ;
    endcase
  end

  always_comb begin
    pat32 = '0;
    act32 = '0;
    pat32[NUM_LEDS-1:0] = pattern_next;
    act32[NUM_LEDS-1:0] = blink_active_next;
    result = {4'd0, shifting_next, pin_str_next, pin_dat_next, pin_clk_next,
              act32[15:0], pat32[15:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count  <= '0;
      blink_active    <= '0;
      pattern         <= '0;
      pattern_changed <= 1'b0;
      shift_word      <= '0;
      shifting        <= 1'b0;
      shift_phase     <= '0;
      bits_left       <= '0;
      pin_clk         <= 1'b0;
      pin_dat         <= 1'b0;
      pin_str         <= 1'b0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        phase[i]       <= '0;
        cycle_len[i]   <= '0;
        off_phase[i]   <= '0;
        cycles_left[i] <= '0;
      end
    end else if (in_fire) begin
      prescale_count  <= prescale_count_next;
      blink_active    <= blink_active_next;
      pattern         <= pattern_next;
      pattern_changed <= pattern_changed_next;
      shift_word      <= shift_word_next;
      shifting        <= shifting_next;
      shift_phase     <= shift_phase_next;
      bits_left       <= bits_left_next;
      pin_clk         <= pin_clk_next;
      pin_dat         <= pin_dat_next;
      pin_str         <= pin_str_next;
      phase           <= phase_next;
      cycle_len       <= cycle_len_next;
      off_phase       <= off_phase_next;
      cycles_left     <= cycles_left_next;
    end
  end

  // output register + skid control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_fire) begin
        // input only fires here while the skid stage is empty
        out_valid  <= skid_valid || in_fire;
        skid_valid <= 1'b0;
      end else if (in_fire) begin
        if (!out_valid) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire && skid_valid) begin
      out_data <= skid_data;
    end else if (in_fire && (!out_valid || m_axis_tready)) begin
      out_data <= result;
    end
    if (in_fire && out_valid && !m_axis_tready) begin
      skid_data <= result;
    end
  end

  // a word in the skid stage always has one ahead of it
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a word while output register is empty");

  // end of a transfer raises the strobe
  a_strobe_at_end: assert property (@(posedge clk) disable iff (rst)
    $fell(shifting) |-> pin_str)
    else $error("transfer ended without strobe");

  // start of a transfer drops the strobe and consumes the pending change
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    $rose(shifting) |-> (!pin_str && !pattern_changed))
    else $error("transfer start left strobe high or change pending");

  // a set command always leaves a change pending
  a_set_marks: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (s_axis_tuser == REQ_SET_LEDS)) |=> pattern_changed)
    else $error("set command did not mark the pattern changed");

  // every accepted word lands in the output register or the skid stage
  a_word_kept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted word produced no result");

endmodule
